@@ hw/rtl/mqlf_pkg.sv @@
// Shared types and constants for the linked-list multi-queue block.
`timescale 1ns / 1ps

package mqlf_pkg;

    // Sizing of the queue set and the shared node store.
    localparam int NUM_QUEUES  = 10;
    localparam int POOL_DEPTH  = 256;
    localparam int VALUE_WIDTH = 32;

    // Derived widths, then the fixed queue ID and data widths.
    localparam int PTR_W  = $clog2(POOL_DEPTH);
    localparam int CNT_W  = PTR_W + 1;
    localparam int QIDX_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int QID_W  = 4;
    localparam int DATA_W = 32;

    // Operation codes carried by an input item.
    typedef enum logic
    {
        ACT_PUSH = 1'b0,
        ACT_POP  = 1'b1
    } action_t;

    // Result status codes.
    typedef enum logic [1:0]
    {
        ST_PUSHED = 2'd0,
        ST_POPPED = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_REJECT = 2'd3
    } status_t;

    // Controller states.
    typedef enum logic
    {
        FSM_IDLE = 1'b0,
        FSM_EXEC = 1'b1
    } fsm_state_t;

    // Input item.
    typedef struct packed
    {
        action_t            action;
        logic [QID_W-1:0]   queue_id;
        logic signed [DATA_W-1:0] push_value;
    } in_item_t;

    // Result item.
    typedef struct packed
    {
        status_t            status;
        logic signed [DATA_W-1:0] pop_value;
        logic [QID_W-1:0]   result_queue;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed
    {
        logic load;
        logic exec;
    } dp_cmd_t;

endpackage

@@ hw/rtl/mqlf_ctrl.sv @@
// Controller state machine that sequences each item through load and execute.
`timescale 1ns / 1ps

module mqlf_ctrl
    import mqlf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    output logic    done,
    output dp_cmd_t cmd
);

    fsm_state_t state_reg;
    fsm_state_t state_next;
    logic       done_reg;
    logic       done_next;

    // State and strobe registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FSM_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cmd.load   = 1'b0;
        cmd.exec   = 1'b0;
        busy       = 1'b0;
        case (state_reg)
            FSM_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = FSM_EXEC;
                end
            end
            FSM_EXEC:
            begin
                busy       = 1'b1;
                cmd.exec   = 1'b1;
                done_next  = 1'b1;
                state_next = FSM_IDLE;
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    assign done = done_reg;

endmodule

@@ hw/rtl/mqlf_dp.sv @@
// Datapath: queue pointers, node store, free stack and the result register.
`timescale 1ns / 1ps

module mqlf_dp
    import mqlf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  dp_cmd_t   cmd,
    input  in_item_t  item,
    output out_item_t result
);

    // Captured item.
    action_t                act_reg;
    logic [QID_W-1:0]       q_reg;
    logic [VALUE_WIDTH-1:0] val_reg;

    // Per-queue state.
    logic [PTR_W-1:0]       head_reg [NUM_QUEUES];
    logic [PTR_W-1:0]       tail_reg [NUM_QUEUES];
    logic [NUM_QUEUES-1:0]  nonempty_reg;

    // Free stack bookkeeping.
    logic [CNT_W-1:0]       free_count_reg;
    logic [POOL_DEPTH-1:0]  free_vld_reg;
    logic                   free_vld_rd_reg;

    // Memories and their registered read data.
    logic [VALUE_WIDTH-1:0] node_value [POOL_DEPTH];
    logic [PTR_W-1:0]       node_next  [POOL_DEPTH];
    logic [PTR_W-1:0]       free_stack [POOL_DEPTH];
    logic [VALUE_WIDTH-1:0] value_rd_reg;
    logic [PTR_W-1:0]       next_rd_reg;
    logic [PTR_W-1:0]       free_rd_reg;

    out_item_t              result_reg;

    // Lookup signals for the incoming item.
    logic                   in_q_ok;
    logic [QIDX_W-1:0]      in_qi;
    logic [PTR_W-1:0]       in_head;
    logic [PTR_W-1:0]       top_addr;

    // Execute-phase signals.
    logic                   q_ok;
    logic [QIDX_W-1:0]      qi;
    logic [PTR_W-1:0]       cur_head;
    logic [PTR_W-1:0]       cur_tail;
    logic [PTR_W-1:0]       free_top;
    logic                   push_ok;
    logic                   pop_ok;
    logic                   stack_not_full;
    out_item_t              result_next;

    // Address the head node of the incoming queue and the top of the free stack.
    always_comb
    begin
        in_q_ok  = (item.queue_id < QID_W'(NUM_QUEUES));
        in_qi    = in_q_ok ? QIDX_W'(item.queue_id) : '0;
        in_head  = head_reg[in_qi];
        top_addr = PTR_W'(free_count_reg - CNT_W'(1));
    end

    // Decode the captured item against the current state.
    always_comb
    begin
        q_ok           = (q_reg < QID_W'(NUM_QUEUES));
        qi             = q_ok ? QIDX_W'(q_reg) : '0;
        cur_head       = head_reg[qi];
        cur_tail       = tail_reg[qi];
        free_top       = free_vld_rd_reg ? free_rd_reg : top_addr;
        stack_not_full = (free_count_reg != CNT_W'(POOL_DEPTH));
        push_ok        = (act_reg == ACT_PUSH) && q_ok && (free_count_reg != '0);
        pop_ok         = (act_reg == ACT_POP) && q_ok && nonempty_reg[qi];

        result_next.result_queue = q_reg;
        result_next.pop_value    = '0;
        if (act_reg == ACT_PUSH)
        begin
            result_next.status = push_ok ? ST_PUSHED : ST_REJECT;
        end
        else
        begin
            result_next.status = pop_ok ? ST_POPPED : ST_EMPTY;
            if (pop_ok)
            begin
                result_next.pop_value = DATA_W'($signed(value_rd_reg));
            end
        end
    end

    // Item capture and result register.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg <= item.action;
            q_reg   <= item.queue_id;
            val_reg <= VALUE_WIDTH'($unsigned(item.push_value));
        end
        if (cmd.exec)
        begin
            result_reg <= result_next;
        end
    end

    // Queue pointers, empty flags and free count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
            end
            nonempty_reg    <= '0;
            free_count_reg  <= CNT_W'(POOL_DEPTH);
            free_vld_reg    <= '0;
            free_vld_rd_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                free_vld_rd_reg <= free_vld_reg[top_addr];
            end
            if (cmd.exec && push_ok)
            begin
                free_count_reg <= free_count_reg - CNT_W'(1);
                tail_reg[qi]   <= free_top;
                if (!nonempty_reg[qi])
                begin
                    head_reg[qi]     <= free_top;
                    nonempty_reg[qi] <= 1'b1;
                end
            end
            if (cmd.exec && pop_ok)
            begin
                if (cur_head == cur_tail)
                begin
                    nonempty_reg[qi] <= 1'b0;
                end
                else
                begin
                    head_reg[qi] <= next_rd_reg;
                end
                if (stack_not_full)
                begin
                    free_count_reg <= free_count_reg + CNT_W'(1);
                    free_vld_reg[free_count_reg[PTR_W-1:0]] <= 1'b1;
                end
            end
        end
    end

    // Node value store.
    always_ff @(posedge clk)
    begin
        if (cmd.exec && push_ok)
        begin
            node_value[free_top] <= val_reg;
        end
        if (cmd.load)
        begin
            value_rd_reg <= node_value[in_head];
        end
    end

    // Node link store; the newest node's link is never followed, so it is not cleared.
    always_ff @(posedge clk)
    begin
        if (cmd.exec && push_ok && nonempty_reg[qi])
        begin
            node_next[cur_tail] <= free_top;
        end
        if (cmd.load)
        begin
            next_rd_reg <= node_next[in_head];
        end
    end

    // Free stack store; for an entry never written, the datapath uses its own index instead.
    always_ff @(posedge clk)
    begin
        if (cmd.exec && pop_ok && stack_not_full)
        begin
            free_stack[free_count_reg[PTR_W-1:0]] <= cur_head;
        end
        if (cmd.load)
        begin
            free_rd_reg <= free_stack[top_addr];
        end
    end

    assign result = result_reg;

endmodule

@@ hw/rtl/multi_queue_linked_fifo_unit.sv @@
// Sequence: an accepted item is captured, and its head node, link and free stack entry are read;
// in the execute state that follows, the result register is loaded and the done strobe is set.
// Busy is high in that execute state, while the node store, link store and free stack are
// updated, and a new item is taken only once the block is back in the idle state.
// The result is shown for one cycle and may overlap the acceptance of the next item.
// Reset: all queues empty and every node free; no clearing pass is needed.
`timescale 1ns / 1ps

module multi_queue_linked_fifo_unit
    import mqlf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  in_item_t  cmd,
    output logic      done,
    output out_item_t result
);

    dp_cmd_t dp_cmd;

    // Sequencing of each item.
    mqlf_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (dp_cmd)
    );

    // Queue state and storage.
    mqlf_dp u_dp
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (dp_cmd),
        .item   (cmd),
        .result (result)
    );

endmodule

@@ test/multi_queue_linked_fifo_unit_check.sv @@
// Checker for the linked-list multi-queue block: predicts every result and compares it.
`timescale 1ns / 1ps

module multi_queue_linked_fifo_unit_check
    import mqlf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic      busy,
    input  in_item_t  cmd,
    input  logic      done,
    input  out_item_t result,
    output int        fail_count,
    output int        pending
);

    // Shadow copy of the queue set, the node store and the free slot stack.
    logic [PTR_W-1:0]       head_slot   [NUM_QUEUES];
    logic [PTR_W-1:0]       tail_slot   [NUM_QUEUES];
    logic                   holds_nodes [NUM_QUEUES];
    logic [VALUE_WIDTH-1:0] node_data   [POOL_DEPTH];
    logic [PTR_W-1:0]       node_link   [POOL_DEPTH];
    logic [PTR_W-1:0]       spare_slots [POOL_DEPTH];
    logic [CNT_W-1:0]       spare_count;

    // Results still owed by the block, oldest first.
    out_item_t awaited_results [$];
    out_item_t awaited;
    int        bad_results;

    // Applies one push or pop to the shadow state and returns the result it earns.
    function automatic out_item_t apply_queue_op(input in_item_t op);
        out_item_t                     outcome;
        logic [PTR_W-1:0]              slot;
        logic signed [VALUE_WIDTH-1:0] stored;
        int                            q;
        outcome.status       = ST_EMPTY;
        outcome.pop_value    = '0;
        outcome.result_queue = op.queue_id;
        q = int'(op.queue_id);
        if (op.action == ACT_PUSH)
        begin
            // A push to a queue that does not exist, or with no slot left, is dropped.
            if (q >= NUM_QUEUES || spare_count == 0)
            begin
                outcome.status = ST_REJECT;
            end
            else
            begin
                spare_count = spare_count - 1'b1;
                slot = spare_slots[spare_count];
                node_data[slot] = VALUE_WIDTH'(op.push_value);
                node_link[slot] = '0;
                if (holds_nodes[q])
                begin
                    node_link[tail_slot[q]] = slot;
                end
                else
                begin
                    head_slot[q]   = slot;
                    holds_nodes[q] = 1'b1;
                end
                tail_slot[q]   = slot;
                outcome.status = ST_PUSHED;
            end
        end
        else if (q < NUM_QUEUES && holds_nodes[q])
        begin
            // Take the head; the last node empties the queue without moving the head.
            slot   = head_slot[q];
            stored = node_data[slot];
            outcome.pop_value = DATA_W'(stored);
            if (slot == tail_slot[q])
            begin
                holds_nodes[q] = 1'b0;
            end
            else
            begin
                head_slot[q] = node_link[slot];
            end
            if (spare_count < POOL_DEPTH)
            begin
                spare_slots[spare_count] = slot;
                spare_count = spare_count + 1'b1;
            end
            outcome.status = ST_POPPED;
        end
        return outcome;
    endfunction

    // Follow both channels: compare each result with the oldest prediction,
    // then predict for an item accepted at the same edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_QUEUES; k++)
            begin
                head_slot[k]   = '0;
                tail_slot[k]   = '0;
                holds_nodes[k] = 1'b0;
            end
            for (int k = 0; k < POOL_DEPTH; k++)
            begin
                spare_slots[k] = PTR_W'(k);
            end
            spare_count = CNT_W'(POOL_DEPTH);
            awaited_results.delete();
            bad_results = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (done)
            begin
                if (awaited_results.size() == 0)
                begin
                    bad_results++;
                    if (bad_results <= 10)
                    begin
                        $display("%0t: result with none outstanding: %s %0d value %h queue %0d",
                                 $realtime, "status", result.status, result.pop_value,
                                 result.result_queue);
                    end
                end
                else
                begin
                    awaited = awaited_results.pop_front();
                    if (result.status !== awaited.status
                        || result.pop_value !== awaited.pop_value
                        || result.result_queue !== awaited.result_queue)
                    begin
                        bad_results++;
                        if (bad_results <= 10)
                        begin
                            $display("%0t: result mismatch: expected status %0d value %h %s %0d",
                                     $realtime, awaited.status, awaited.pop_value,
                                     "queue", awaited.result_queue);
                            $display("%0t:                  got status %0d value %h queue %0d",
                                     $realtime, result.status, result.pop_value,
                                     result.result_queue);
                        end
                    end
                end
            end
            if (start && !busy)
            begin
                awaited_results.push_back(apply_queue_op(cmd));
            end
            fail_count <= bad_results;
            pending    <= awaited_results.size();
        end
    end

endmodule

@@ test/multi_queue_linked_fifo_unit_test.sv @@
// Testbench top for the linked-list multi-queue block: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module multi_queue_linked_fifo_unit_test;
    import mqlf_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    in_item_t  cmd;
    logic      done;
    out_item_t result;
    int        fail_count;
    int        pending;
    int        sender_idle_pct;

    multi_queue_linked_fifo_unit dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    multi_queue_linked_fifo_unit_check checker_inst
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .done       (done),
        .result     (result),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // 100 MHz clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Builds one input item.
    function automatic in_item_t make_cmd(input action_t act, input logic [QID_W-1:0] qid,
                                          input logic [DATA_W-1:0] value);
        in_item_t it;
        it.action     = act;
        it.queue_id   = qid;
        it.push_value = value;
        return it;
    endfunction

    // Offers one item from a falling edge, with random idle cycles first,
    // and returns at the falling edge after the item is accepted.
    task automatic offer_item(input in_item_t it);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        cmd   <= it;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // Fills the whole node store, pushes past the limit, then pops round the queues.
    task automatic fill_and_drain();
        for (int k = 0; k < POOL_DEPTH + 4; k++)
        begin
            offer_item(make_cmd(ACT_PUSH, QID_W'($urandom_range(NUM_QUEUES - 1)), $urandom()));
        end
        for (int k = 0; k < POOL_DEPTH + 4; k++)
        begin
            offer_item(make_cmd(ACT_POP, QID_W'(k % NUM_QUEUES), $urandom()));
        end
    endtask

    // Random traffic in bursts that lean towards pushes, pops or neither,
    // mostly aimed at one busy queue so that long lists build up.
    task automatic run_traffic(input int count);
        int                sent;
        int                burst;
        int                push_pct;
        logic [QID_W-1:0]  hot;
        logic [QID_W-1:0]  qid;
        action_t           act;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(80, 10);
            case ($urandom_range(2))
                0:       push_pct = 85;
                1:       push_pct = 50;
                default: push_pct = 15;
            endcase
            hot = QID_W'($urandom_range(NUM_QUEUES - 1));
            for (int k = 0; k < burst && sent < count; k++)
            begin
                act = ($urandom_range(99) < push_pct) ? ACT_PUSH : ACT_POP;
                if ($urandom_range(15) == 0)
                begin
                    qid = QID_W'($urandom_range(15, NUM_QUEUES));
                end
                else if ($urandom_range(1) == 1)
                begin
                    qid = hot;
                end
                else
                begin
                    qid = QID_W'($urandom_range(NUM_QUEUES - 1));
                end
                offer_item(make_cmd(act, qid, $urandom()));
                sent++;
            end
        end
    endtask

    // Reset, directed items, pool exhaustion, then three phases of random traffic.
    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        cmd   = '0;
        sender_idle_pct = 24;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Empty pops, extreme values, queues that do not exist, and the last node.
        offer_item(make_cmd(ACT_POP,  4'd0,  32'h0000_0000));
        offer_item(make_cmd(ACT_PUSH, 4'd0,  32'h7FFF_FFFF));
        offer_item(make_cmd(ACT_PUSH, 4'd0,  32'h8000_0000));
        offer_item(make_cmd(ACT_PUSH, 4'd9,  32'hFFFF_FFFF));
        offer_item(make_cmd(ACT_PUSH, 4'd9,  32'h0000_0000));
        offer_item(make_cmd(ACT_PUSH, 4'd10, 32'h5555_5555));
        offer_item(make_cmd(ACT_PUSH, 4'd15, 32'hAAAA_AAAA));
        offer_item(make_cmd(ACT_POP,  4'd15, 32'hFFFF_FFFF));
        offer_item(make_cmd(ACT_POP,  4'd10, 32'h0000_0000));
        offer_item(make_cmd(ACT_POP,  4'd0,  32'h0000_0000));
        offer_item(make_cmd(ACT_POP,  4'd0,  32'h0000_0000));
        offer_item(make_cmd(ACT_POP,  4'd0,  32'h0000_0000));
        offer_item(make_cmd(ACT_POP,  4'd9,  32'h0000_0000));
        offer_item(make_cmd(ACT_PUSH, 4'd9,  32'h1234_5678));
        offer_item(make_cmd(ACT_PUSH, 4'd5,  32'h0000_0001));
        offer_item(make_cmd(ACT_POP,  4'd9,  32'h0000_0000));
        offer_item(make_cmd(ACT_POP,  4'd9,  32'h0000_0000));
        offer_item(make_cmd(ACT_POP,  4'd9,  32'h0000_0000));
        offer_item(make_cmd(ACT_POP,  4'd5,  32'h0000_0000));
        offer_item(make_cmd(ACT_POP,  4'd5,  32'h0000_0000));

        // Pool exhaustion, then random traffic with the sender idling now and then,
        // then often, then never.
        fill_and_drain();
        run_traffic(500);
        sender_idle_pct = 82;
        run_traffic(400);
        sender_idle_pct = 0;
        run_traffic(600);
        start <= 1'b0;

        // Wait for the last results, then a little longer for strays.
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (6) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("multi_queue_linked_fifo_unit verification clean");
        end
        else
        begin
            $display("multi_queue_linked_fifo_unit verification failed");
        end
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial
    begin
        #5_000_000;
        $display("multi_queue_linked_fifo_unit verification failed");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/mqlf_pkg.sv
hw/rtl/mqlf_ctrl.sv
hw/rtl/mqlf_dp.sv
hw/rtl/multi_queue_linked_fifo_unit.sv
test/multi_queue_linked_fifo_unit_check.sv
test/multi_queue_linked_fifo_unit_test.sv
